>>> hdl/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/umlw_pkg.sv
`timescale 1ns / 1ps
package umlw_pkg;

    localparam int FRAG_MAX_DEF = 4096;
    localparam int IQ_DEPTH     = 2;
    localparam int RQ_DEPTH     = 4;
    localparam int DIV_STEPS    = 24;

    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] MASK_C0   = 8'hc0;
    localparam logic [7:0] MASK_E0   = 8'he0;
    localparam logic [7:0] MASK_F0   = 8'hf0;
    localparam logic [7:0] MASK_F8   = 8'hf8;
    localparam logic [7:0] PAT_CONT  = 8'h80;
    localparam logic [7:0] PAT_LEAD2 = 8'hc0;
    localparam logic [7:0] PAT_LEAD3 = 8'he0;
    localparam logic [7:0] PAT_LEAD4 = 8'hf0;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_FRAG   = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_LAYOUT_W = 3'd0,
        CFG_ADVANCE  = 3'd1,
        CFG_PITCH    = 3'd2,
        CFG_SIDE_PAD = 3'd3,
        CFG_VERT_PAD = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } t_cls;

    typedef enum logic [1:0] {
        CP_ONE,
        CP_TAB,
        CP_NL
    } t_cp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_YFIN,
        S_BYTE,
        S_LEAD,
        S_CONS,
        S_EMIT_MUL,
        S_EMIT_OUT,
        S_END,
        S_END2,
        S_STATUS,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data_byte;
        t_cls        cls;
        logic [39:0] resume_offset;
        logic [31:0] resume_line;
        logic [47:0] window_top;
        logic [47:0] window_bottom;
        logic [12:0] fragment_limit;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_front_out;

    typedef struct packed {
        t_kind       kind;
        logic [39:0] range_begin;
        logic [39:0] range_end;
        logic [47:0] line_y;
        logic [31:0] line_width;
        logic        newline_end;
        logic        truncated;
        logic        stopped;
        logic        last;
    } t_result;

endpackage

>>> hdl/umlw_front.sv
`timescale 1ns / 1ps
module umlw_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [1:0]             i_cmd,
    input  logic [7:0]             i_data_byte,
    input  logic [39:0]            i_resume_offset,
    input  logic [31:0]            i_resume_line,
    input  logic [47:0]            i_window_top_q8,
    input  logic [47:0]            i_window_bottom_q8,
    input  logic [12:0]            i_fragment_limit,
    output umlw_pkg::t_front_out   o_front,
    input  logic                   i_pop
);
    import umlw_pkg::*;

    localparam int PW = $clog2(IQ_DEPTH);

    t_item             r_mem [IQ_DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [PW:0]       r_count;
    t_item             w_item;
    t_cls              w_cls;
    logic              w_wr, w_rd;

    always_comb begin
        if (!i_data_byte[7])                                w_cls = CLS_ASCII;
        else if ((i_data_byte & MASK_C0) == PAT_CONT)       w_cls = CLS_CONT;
        else if ((i_data_byte & MASK_E0) == PAT_LEAD2)      w_cls = CLS_LEAD2;
        else if ((i_data_byte & MASK_F0) == PAT_LEAD3)      w_cls = CLS_LEAD3;
        else if ((i_data_byte & MASK_F8) == PAT_LEAD4)      w_cls = CLS_LEAD4;
        else                                                w_cls = CLS_BAD;
    end

    always_comb begin
        w_item.cmd            = t_cmd'(i_cmd);
        w_item.data_byte      = i_data_byte;
        w_item.cls            = w_cls;
        w_item.resume_offset  = i_resume_offset;
        w_item.resume_line    = i_resume_line;
        w_item.window_top     = i_window_top_q8;
        w_item.window_bottom  = i_window_bottom_q8;
        w_item.fragment_limit = i_fragment_limit;
    end

    assign o_full        = (r_count == (PW+1)'(IQ_DEPTH));
    assign w_wr          = i_push && !o_full;
    assign w_rd          = i_pop && (r_count != '0);
    assign o_front.valid = (r_count != '0);
    assign o_front.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= w_item;
    end

endmodule

>>> hdl/umlw_rfifo.sv
`timescale 1ns / 1ps
module umlw_rfifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  umlw_pkg::t_result    i_wdata,
    output logic                 o_empty,
    input  logic                 i_pop,
    output umlw_pkg::t_result    o_rdata,
    output logic [$clog2(umlw_pkg::RQ_DEPTH):0] o_count
);
    import umlw_pkg::*;

    localparam int PW = $clog2(RQ_DEPTH);

    t_result       r_mem [RQ_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_count;
    logic          w_rd;

    assign o_empty = (r_count == '0);
    assign w_rd    = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_wdata;
    end

endmodule

>>> hdl/umlw_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module umlw_back #(
    parameter int FRAGMENT_MAX = umlw_pkg::FRAG_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr,
    input  logic [2:0]             i_cfg_addr,
    input  logic [23:0]            i_cfg_data,
    input  umlw_pkg::t_front_out   i_front,
    output logic                   o_pop,
    input  logic [$clog2(umlw_pkg::RQ_DEPTH):0] i_rq_count,
    output logic                   o_wr,
    output umlw_pkg::t_result      o_wdata
);
    import umlw_pkg::*;

    localparam int          CW      = $clog2(RQ_DEPTH) + 1;
    localparam logic [16:0] FM      = 17'(FRAGMENT_MAX);
    localparam logic [4:0]  DIV_END = 5'(DIV_STEPS - 1);

    logic [23:0] r_layout;
    logic [15:0] r_adv, r_pitch, r_side, r_vert;

    t_state      r_state, n_state, r_ret, n_ret;
    t_item       r_item, n_item;
    t_cp         r_cp, n_cp;
    logic        r_hard, n_hard;
    logic [39:0] r_offset, n_offset, r_lbeg, n_lbeg;
    logic [24:0] r_col, n_col;
    logic [23:0] r_cpr, n_cpr, r_cw, n_cw;
    logic [47:0] r_y, n_y, r_top, n_top, r_bot, n_bot;
    logic [1:0]  r_pend, n_pend;
    logic [12:0] r_emit, n_emit, r_limit, n_limit;
    logic        r_stop, n_stop, r_trunc, n_trunc, r_active, n_active;
    logic [47:0] r_prod, n_prod;
    logic [15:0] r_rem, n_rem;
    logic [23:0] r_quo, n_quo;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_hold_v, n_hold_v;
    t_result     r_hold, n_hold;

    logic        w_res_v;
    t_result     w_res;
    logic [15:0] w_adv1;
    logic [16:0] w_side2, w_rem_sh;
    logic [39:0] w_off_inc;
    logic [48:0] w_ysum, w_ystart;
    logic        w_meets, w_can;
    logic [12:0] w_emit_n;
    logic [47:0] w_wmax;
    logic [23:0] w_wfin;
    logic [24:0] w_col_n;
    logic [1:0]  w_pend_n;
    logic [23:0] w_cw_start;

    assign w_adv1     = (r_adv == '0) ? 16'd1 : r_adv;
    assign w_side2    = {r_side, 1'b0};
    assign w_cw_start = ({1'b0, r_layout} > {7'd0, w_side2})
                        ? (r_layout - {7'd0, w_side2}) : {8'd0, r_adv};
    assign w_rem_sh   = {r_rem, r_quo[23]};
    assign w_off_inc  = (r_offset == '1) ? r_offset : r_offset + 40'd1;
    assign w_ysum     = {1'b0, r_y} + {33'd0, r_pitch};
    assign w_ystart   = {1'b0, r_prod} + {34'd0, r_vert[15:1]};
    assign w_meets    = (w_ysum > {1'b0, r_top}) && (r_y < r_bot);
    assign w_can      = (r_emit < r_limit);
    assign w_emit_n   = r_emit + {12'd0, (w_meets && w_can)};
    assign w_wmax     = (r_prod > {32'd0, r_adv}) ? r_prod : {32'd0, r_adv};
    assign w_wfin     = (w_wmax > {24'd0, r_cw}) ? r_cw : w_wmax[23:0];
    assign w_col_n    = r_col + ((r_cp == CP_TAB) ? 25'd4 : 25'd1);
    assign w_pend_n   = r_pend - 2'd1;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_item   = r_item;
        n_cp     = r_cp;
        n_hard   = r_hard;
        n_offset = r_offset;
        n_lbeg   = r_lbeg;
        n_col    = r_col;
        n_cpr    = r_cpr;
        n_cw     = r_cw;
        n_y      = r_y;
        n_top    = r_top;
        n_bot    = r_bot;
        n_pend   = r_pend;
        n_emit   = r_emit;
        n_limit  = r_limit;
        n_stop   = r_stop;
        n_trunc  = r_trunc;
        n_active = r_active;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        o_pop    = 1'b0;
        w_res_v  = 1'b0;
        w_res    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_front.valid && (i_rq_count <= CW'(1))) begin
                    o_pop  = 1'b1;
                    n_item = i_front.item;
                    unique case (i_front.item.cmd)
                        CMD_START: begin
                            if ((i_front.item.fragment_limit == '0) ||
                                (i_front.item.window_bottom <= i_front.item.window_top)) begin
                                n_active   = 1'b0;
                                w_res_v    = 1'b1;
                                w_res.kind = KIND_REJECT;
                                n_state    = S_DONE;
                            end else begin
                                n_cw     = w_cw_start;
                                n_rem    = '0;
                                n_quo    = w_cw_start;
                                n_cnt    = '0;
                                n_prod   = {16'd0, i_front.item.resume_line} * {32'd0, r_pitch};
                                n_offset = i_front.item.resume_offset;
                                n_lbeg   = i_front.item.resume_offset;
                                n_col    = '0;
                                n_top    = i_front.item.window_top;
                                n_bot    = i_front.item.window_bottom;
                                n_limit  = ({4'd0, i_front.item.fragment_limit} > FM)
                                           ? FM[12:0] : i_front.item.fragment_limit;
                                n_pend   = '0;
                                n_emit   = '0;
                                n_stop   = 1'b0;
                                n_trunc  = 1'b0;
                                n_active = 1'b1;
                                n_state  = S_DIV;
                            end
                        end
                        CMD_BYTE: n_state = (r_active && !r_stop) ? S_BYTE : S_DONE;
                        CMD_END:  n_state = S_END;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (w_rem_sh >= {1'b0, w_adv1}) begin
                    n_rem = 16'(w_rem_sh - {1'b0, w_adv1});
                    n_quo = {r_quo[22:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[15:0];
                    n_quo = {r_quo[22:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_END) n_state = S_YFIN;
            end
            S_YFIN: begin
                n_cpr   = (r_quo == '0) ? 24'd1 : r_quo;
                n_y     = w_ystart[48] ? '1 : w_ystart[47:0];
                n_state = S_DONE;
            end
            S_BYTE: begin
                if (r_pend != '0) begin
                    if (r_item.cls == CLS_CONT) begin
                        n_pend   = w_pend_n;
                        n_offset = w_off_inc;
                        if (w_pend_n == '0) begin
                            n_cp    = CP_ONE;
                            n_ret   = S_DONE;
                            n_state = S_CONS;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_pend  = '0;
                        n_cp    = CP_ONE;
                        n_ret   = S_LEAD;
                        n_state = S_CONS;
                    end
                end else begin
                    n_state = S_LEAD;
                end
            end
            S_LEAD: begin
                if (r_stop) begin
                    n_state = S_DONE;
                end else begin
                    n_offset = w_off_inc;
                    n_ret    = S_DONE;
                    n_state  = S_DONE;
                    unique case (r_item.cls)
                        CLS_ASCII: begin
                            if (r_item.data_byte == CH_NL)       n_cp = CP_NL;
                            else if (r_item.data_byte == CH_TAB) n_cp = CP_TAB;
                            else                                 n_cp = CP_ONE;
                            n_state = S_CONS;
                        end
                        CLS_LEAD2: n_pend = 2'd1;
                        CLS_LEAD3: n_pend = 2'd2;
                        CLS_LEAD4: n_pend = 2'd3;
                        default: begin
                            n_cp    = CP_ONE;
                            n_state = S_CONS;
                        end
                    endcase
                end
            end
            S_CONS: begin
                if (r_cp == CP_NL) begin
                    n_hard  = 1'b1;
                    n_state = S_EMIT_MUL;
                end else begin
                    n_col = w_col_n;
                    if (w_col_n >= {1'b0, r_cpr}) begin
                        n_hard  = 1'b0;
                        n_state = S_EMIT_MUL;
                    end else begin
                        n_state = r_ret;
                    end
                end
            end
            S_EMIT_MUL: begin
                n_prod  = {23'd0, r_col} * {32'd0, r_adv};
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (w_meets && w_can) begin
                    w_res_v           = 1'b1;
                    w_res.kind        = KIND_FRAG;
                    w_res.range_begin = r_lbeg;
                    w_res.range_end   = r_offset;
                    w_res.line_y      = r_y;
                    w_res.line_width  = {8'd0, w_wfin};
                    w_res.newline_end = r_hard;
                end
                if (w_meets && !w_can) n_trunc = 1'b1;
                n_emit = w_emit_n;
                n_y    = w_ysum[48] ? '1 : w_ysum[47:0];
                n_lbeg = r_offset;
                n_col  = '0;
                if ((r_y >= r_bot) || (w_emit_n >= r_limit)) n_stop = 1'b1;
                n_state = r_ret;
            end
            S_END: begin
                if (!r_active) begin
                    n_state = S_STATUS;
                end else if (!r_stop && (r_pend != '0)) begin
                    n_pend  = '0;
                    n_cp    = CP_ONE;
                    n_ret   = S_END2;
                    n_state = S_CONS;
                end else begin
                    n_state = S_END2;
                end
            end
            S_END2: begin
                if (r_active && !r_stop && ((r_lbeg < r_offset) || (r_emit == '0))) begin
                    n_hard  = 1'b0;
                    n_ret   = S_STATUS;
                    n_state = S_EMIT_MUL;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                n_active        = 1'b0;
                w_res_v         = 1'b1;
                w_res.kind      = KIND_STATUS;
                w_res.truncated = r_trunc;
                w_res.stopped   = r_stop;
                n_state         = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // last result of an item is held back until the item completes
    always_comb begin
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        o_wr     = 1'b0;
        o_wdata  = r_hold;
        if (w_res_v) begin
            o_wr          = r_hold_v;
            o_wdata.last  = 1'b0;
            n_hold        = w_res;
            n_hold_v      = 1'b1;
        end else if (r_state == S_DONE) begin
            o_wr          = r_hold_v;
            o_wdata.last  = 1'b1;
            n_hold_v      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_DONE;
            r_offset <= '0;
            r_lbeg   <= '0;
            r_col    <= '0;
            r_cpr    <= 24'd1;
            r_cw     <= '0;
            r_y      <= '0;
            r_top    <= '0;
            r_bot    <= '0;
            r_pend   <= '0;
            r_emit   <= '0;
            r_limit  <= '0;
            r_stop   <= 1'b0;
            r_trunc  <= 1'b0;
            r_active <= 1'b0;
            r_hold_v <= 1'b0;
            r_layout <= '0;
            r_adv    <= 16'd256;
            r_pitch  <= 16'd4096;
            r_side   <= '0;
            r_vert   <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_offset <= n_offset;
            r_lbeg   <= n_lbeg;
            r_col    <= n_col;
            r_cpr    <= n_cpr;
            r_cw     <= n_cw;
            r_y      <= n_y;
            r_top    <= n_top;
            r_bot    <= n_bot;
            r_pend   <= n_pend;
            r_emit   <= n_emit;
            r_limit  <= n_limit;
            r_stop   <= n_stop;
            r_trunc  <= n_trunc;
            r_active <= n_active;
            r_hold_v <= n_hold_v;
            if (i_cfg_wr) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_LAYOUT_W: r_layout <= i_cfg_data;
                    CFG_ADVANCE:  r_adv    <= i_cfg_data[15:0];
                    CFG_PITCH:    r_pitch  <= i_cfg_data[15:0];
                    CFG_SIDE_PAD: r_side   <= i_cfg_data[15:0];
                    CFG_VERT_PAD: r_vert   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_cp   <= n_cp;
        r_hard <= n_hard;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_hold <= n_hold;
    end

    `ASSERT_CLK(a_rq_no_overflow, i_clk, i_rst_n, o_wr |-> (i_rq_count < CW'(RQ_DEPTH)), "rq overflow")
    `ASSERT_CLK(a_emit_in_limit, i_clk, i_rst_n, r_active |-> (r_emit <= r_limit), "count past limit")
    `ASSERT_CLK(a_hold_flushed, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_hold_v, "hold not flushed")

endmodule

>>> hdl/utf8_monospace_line_wrapper_unit.sv
`timescale 1ns / 1ps
// UTF-8 line wrapper. Input side is a queue: drive the item on the i_ fields and
// raise i_push; the beat is taken when o_full is low. A record is one start
// beat, one beat per source byte and one end beat. Result side is a queue too:
// while o_empty is low the oldest result sits on the o_ fields, and i_pop takes
// it. o_last marks the final result of one input beat.
// Configuration: i_cfg_wr writes i_cfg_data to register i_cfg_addr in the same
// edge; write only while the block is idle.
// Structure: a two-deep input queue feeds a sequencer that handles one item at a
// time. A valid start runs a 24-step divider for columns per row; a rejected
// start emits a reject result. A byte passes decode and a column step, and
// per emitted line a multiply state and an output state.
// The sequencer takes a new item only with three free slots in the four-deep
// result queue, so a stalled receiver stops it cleanly and nothing is lost.
// Reset (synchronous, active low) empties both queues, clears the record
// state and loads register defaults.
module utf8_monospace_line_wrapper_unit #(
    parameter int FRAGMENT_MAX = umlw_pkg::FRAG_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [39:0] i_resume_offset,
    input  logic [31:0] i_resume_line,
    input  logic [47:0] i_window_top_q8,
    input  logic [47:0] i_window_bottom_q8,
    input  logic [12:0] i_fragment_limit,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic [39:0] o_range_begin,
    output logic [39:0] o_range_end,
    output logic [47:0] o_line_y_q8,
    output logic [31:0] o_line_width_q8,
    output logic        o_newline_end,
    output logic        o_truncated,
    output logic        o_stopped,
    output logic        o_last
);
    import umlw_pkg::*;

    t_front_out                w_front;
    logic                      w_pop, w_wr;
    t_result                   w_wdata, w_rdata;
    logic [$clog2(RQ_DEPTH):0] w_rq_count;

    umlw_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_cmd              (i_cmd),
        .i_data_byte        (i_data_byte),
        .i_resume_offset    (i_resume_offset),
        .i_resume_line      (i_resume_line),
        .i_window_top_q8    (i_window_top_q8),
        .i_window_bottom_q8 (i_window_bottom_q8),
        .i_fragment_limit   (i_fragment_limit),
        .o_front            (w_front),
        .i_pop              (w_pop)
    );

    umlw_back #(
        .FRAGMENT_MAX (FRAGMENT_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_wr),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_front    (w_front),
        .o_pop      (w_pop),
        .i_rq_count (w_rq_count),
        .o_wr       (w_wr),
        .o_wdata    (w_wdata)
    );

    umlw_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wdata),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_rdata (w_rdata),
        .o_count (w_rq_count)
    );

    assign o_kind          = w_rdata.kind;
    assign o_range_begin   = w_rdata.range_begin;
    assign o_range_end     = w_rdata.range_end;
    assign o_line_y_q8     = w_rdata.line_y;
    assign o_line_width_q8 = w_rdata.line_width;
    assign o_newline_end   = w_rdata.newline_end;
    assign o_truncated     = w_rdata.truncated;
    assign o_stopped       = w_rdata.stopped;
    assign o_last          = w_rdata.last;

endmodule
